@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/stft_pkg.sv @@
package stft_pkg;

    // default sizes
    localparam int FRAME_LEN_DEF    = 64;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int MAX_FRAME        = 64;
    localparam int MAX_LOG          = 6;

    // field and datapath widths
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int TW_W        = 17;
    localparam int DW          = 25;
    localparam int OUT_W       = 23;
    localparam int FRAME_W     = 32;
    localparam int CH_W        = 3;
    localparam int CC_W        = 4;
    localparam int HOP_W       = 7;
    localparam int BIN_W       = 6;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 88;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    // register reset values
    localparam logic [CC_W-1:0]  CC_RESET  = 4'd1;
    localparam logic [HOP_W-1:0] HOP_RESET = 7'd32;

    // register index, taken from paddr bit 2
    typedef enum logic {
        REG_CHANNEL_COUNT = 1'b0,
        REG_HOP_LENGTH    = 1'b1
    } reg_idx_t;

    // item kind
    localparam logic KIND_PAD = 1'b1;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic [COEF_W-1:0]      win_tab_t [MAX_FRAME];
    typedef logic signed [TW_W-1:0] tw_tab_t  [MAX_FRAME/2];

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_MUL,
        ST_LD_WR,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_SUM,
        ST_BF_WRP,
        ST_BF_WRQ,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic take;
        logic ld_rd;
        logic ld_mul;
        logic ld_wr;
        logic bf_rd;
        logic bf_mul;
        logic bf_sum;
        logic bf_wr_p;
        logic bf_wr_q;
        logic out_rd;
        logic out_ld;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic frame_due;
        logic ld_last;
        logic bf_last;
        logic out_last;
        logic out_free;
    } sts_t;

    // sin(pi*num/Den) in q30, truncating taylor series to x^11
    function automatic logic [63:0] sin_q30(input int unsigned num, input int unsigned Den);
        logic [63:0]    m;
        logic [63:0]    x;
        logic [63:0]    x2;
        logic [63:0]    term;
        longint         sum;
        int unsigned    nn;
        nn = (num > Den) ? Den : num;
        m = (nn < Den - nn) ? 64'(nn) : 64'(Den - nn);
        x = (PI_Q30 * m) / Den;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum = sum - longint'(term);
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) << 30))
            sum = longint'(1) << 30;
        return 64'(sum);
    endfunction

    function automatic logic [63:0] round15(input logic [63:0] q);
        return (q + 64'd16384) >> 15;
    endfunction

    // symmetric hann window, q15
    function automatic win_tab_t build_win(input int unsigned Size);
        win_tab_t    tab;
        logic [63:0] s;
        logic [63:0] w;
        for (int unsigned n = 0; n < MAX_FRAME; n++)
        begin
            tab[n] = '0;
            if (n < Size)
            begin
                s = sin_q30(n, Size - 1);
                w = (s * s + (64'd1 << 44)) >> 45;
                tab[n] = (w > 64'd32767) ? COEF_W'(32767) : COEF_W'(w);
            end
        end
        return tab;
    endfunction

    // twiddle cosine of 2*pi*k/Size
    function automatic tw_tab_t build_cos(input int unsigned Size);
        tw_tab_t     tab;
        int unsigned a;
        for (int unsigned n = 0; n < MAX_FRAME/2; n++)
        begin
            tab[n] = '0;
            a = 2 * n;
            if (n < Size / 2)
            begin
                if (a <= Size / 2)
                    tab[n] = TW_W'(round15(sin_q30(Size / 2 - a, Size)));
                else
                    tab[n] = -TW_W'(round15(sin_q30(a - Size / 2, Size)));
            end
        end
        return tab;
    endfunction

    // twiddle sine of 2*pi*k/Size
    function automatic tw_tab_t build_sin(input int unsigned Size);
        tw_tab_t tab;
        for (int unsigned n = 0; n < MAX_FRAME/2; n++)
        begin
            tab[n] = '0;
            if (n < Size / 2)
                tab[n] = TW_W'(round15(sin_q30(2 * n, Size)));
        end
        return tab;
    endfunction

    // saturate a bin value to the output width
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] hi;
        logic signed [DW-1:0] lo;
        hi = DW'((2 ** (OUT_W - 1)) - 1);
        lo = -DW'(2 ** (OUT_W - 1));
        if (v > hi)
            return hi[OUT_W-1:0];
        else if (v < lo)
            return lo[OUT_W-1:0];
        else
            return v[OUT_W-1:0];
    endfunction

endpackage

@@ rtl/stft_ctrl.sv @@
module stft_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  stft_pkg::sts_t  sts,
    output stft_pkg::cmd_t  cmd
);

    stft_pkg::state_t state_reg;
    stft_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= stft_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stft_pkg::ST_CLEAR:
                if (sts.clr_done)
                    state_next = stft_pkg::ST_IDLE;
            stft_pkg::ST_IDLE:
                if (s_tvalid && sts.frame_due)
                    state_next = stft_pkg::ST_LD_RD;
            stft_pkg::ST_LD_RD:  state_next = stft_pkg::ST_LD_MUL;
            stft_pkg::ST_LD_MUL: state_next = stft_pkg::ST_LD_WR;
            stft_pkg::ST_LD_WR:
                state_next = sts.ld_last ? stft_pkg::ST_BF_RD : stft_pkg::ST_LD_RD;
            stft_pkg::ST_BF_RD:  state_next = stft_pkg::ST_BF_MUL;
            stft_pkg::ST_BF_MUL: state_next = stft_pkg::ST_BF_SUM;
            stft_pkg::ST_BF_SUM: state_next = stft_pkg::ST_BF_WRP;
            stft_pkg::ST_BF_WRP: state_next = stft_pkg::ST_BF_WRQ;
            stft_pkg::ST_BF_WRQ:
                state_next = sts.bf_last ? stft_pkg::ST_OUT_RD : stft_pkg::ST_BF_RD;
            stft_pkg::ST_OUT_RD: state_next = stft_pkg::ST_OUT_LD;
            stft_pkg::ST_OUT_LD:
                if (sts.out_free)
                    state_next = sts.out_last ? stft_pkg::ST_IDLE : stft_pkg::ST_OUT_RD;
            default:
                state_next = stft_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            stft_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
            stft_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            stft_pkg::ST_LD_RD:  cmd.ld_rd   = 1'b1;
            stft_pkg::ST_LD_MUL: cmd.ld_mul  = 1'b1;
            stft_pkg::ST_LD_WR:  cmd.ld_wr   = 1'b1;
            stft_pkg::ST_BF_RD:  cmd.bf_rd   = 1'b1;
            stft_pkg::ST_BF_MUL: cmd.bf_mul  = 1'b1;
            stft_pkg::ST_BF_SUM: cmd.bf_sum  = 1'b1;
            stft_pkg::ST_BF_WRP: cmd.bf_wr_p = 1'b1;
            stft_pkg::ST_BF_WRQ: cmd.bf_wr_q = 1'b1;
            stft_pkg::ST_OUT_RD: cmd.out_rd  = 1'b1;
            stft_pkg::ST_OUT_LD: cmd.out_ld  = sts.out_free;
            default:             cmd         = '0;
        endcase
    end

endmodule

@@ rtl/stft_dp.sv @@
module stft_dp #(
    parameter int FRAME_LEN    = stft_pkg::FRAME_LEN_DEF,
    parameter int MAX_CHANNELS = stft_pkg::MAX_CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  stft_pkg::cmd_t                     cmd,
    output stft_pkg::sts_t                     sts,
    input  logic [stft_pkg::CC_W-1:0]          channel_count,
    input  logic [stft_pkg::HOP_W-1:0]         hop_length,
    input  logic [stft_pkg::TDATA_IN_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stft_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                               m_tlast
);

    localparam int LOGN   = $clog2(FRAME_LEN);
    localparam int HALF   = FRAME_LEN / 2;
    localparam int BW     = LOGN - 1;
    localparam int STW    = $clog2(LOGN);
    localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HDEPTH = MAX_CHANNELS * FRAME_LEN;
    localparam int HAW    = $clog2(HDEPTH);
    localparam int DW     = stft_pkg::DW;
    localparam int SW     = stft_pkg::SAMPLE_W;
    localparam int PW     = stft_pkg::SAMPLE_W + stft_pkg::COEF_W + 1;
    localparam int MW     = stft_pkg::DW + stft_pkg::TW_W;
    localparam int FW     = stft_pkg::FRAME_W;

    localparam stft_pkg::win_tab_t WIN_TAB = stft_pkg::build_win(FRAME_LEN);
    localparam stft_pkg::tw_tab_t  COS_TAB = stft_pkg::build_cos(FRAME_LEN);
    localparam stft_pkg::tw_tab_t  SIN_TAB = stft_pkg::build_sin(FRAME_LEN);

    localparam logic signed [PW-1:0] RND_P = PW'(16384);
    localparam logic signed [MW:0]   RND_M = (MW+1)'(16384);

    // input item fields
    logic                       in_pad;
    logic [stft_pkg::CH_W-1:0]  in_ch;
    logic [SW-1:0]              in_sample;

    assign in_pad    = (s_tuser == stft_pkg::KIND_PAD);
    assign in_ch     = s_tdata[2:0];
    assign in_sample = s_tdata[18:3];

    // stream position state
    logic [FW-1:0]               pos_reg;
    logic [FW-1:0]               real_cnt_reg;
    logic                        pad_reg;
    logic [stft_pkg::HOP_W-1:0]  phase_reg;
    logic [FW-1:0]               frame_cnt_reg;

    // snapshot of the item being transformed
    logic [CHW-1:0]              cur_ch_reg;
    logic [LOGN-1:0]             cur_pos_reg;
    logic [FW-1:0]               cur_frame_reg;

    logic [stft_pkg::CC_W-1:0]   cc_eff;
    logic [stft_pkg::HOP_W-1:0]  hop_eff;
    logic                        in_valid;
    logic                        is_last_ch;
    logic                        pad_eff;
    logic [FW-1:0]               real_eff;
    logic [FW-1:0]               start;
    logic                        pos_full;
    logic                        frame_due;

    // effective register values
    always_comb
    begin
        if (channel_count == '0)
            cc_eff = stft_pkg::CC_W'(1);
        else if (channel_count > stft_pkg::CC_W'(MAX_CHANNELS))
            cc_eff = stft_pkg::CC_W'(MAX_CHANNELS);
        else
            cc_eff = channel_count;
        hop_eff = (hop_length == '0) ? stft_pkg::HOP_W'(1) : hop_length;
    end

    // frame decision for the offered item
    assign in_valid   = {1'b0, in_ch} < cc_eff;
    assign is_last_ch = {1'b0, in_ch} == (cc_eff - stft_pkg::CC_W'(1));
    assign pad_eff    = pad_reg | in_pad;
    assign real_eff   = (in_pad && !pad_reg) ? pos_reg : real_cnt_reg;
    assign start      = pos_reg - FW'(FRAME_LEN - 1);
    assign pos_full   = pos_reg >= FW'(FRAME_LEN - 1);
    assign frame_due  = in_valid && pos_full && (phase_reg == '0)
                        && (!pad_eff || (start < real_eff));

    // stream state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            real_cnt_reg  <= '0;
            pad_reg       <= 1'b0;
            phase_reg     <= '0;
            frame_cnt_reg <= '0;
        end
        else if (cmd.take && in_valid)
        begin
            if (in_pad && !pad_reg)
            begin
                pad_reg      <= 1'b1;
                real_cnt_reg <= pos_reg;
            end
            if (is_last_ch)
            begin
                if (frame_due)
                    frame_cnt_reg <= frame_cnt_reg + FW'(1);
                if (pos_full)
                begin
                    if (({1'b0, phase_reg} + 8'd1) >= {1'b0, hop_eff})
                        phase_reg <= '0;
                    else
                        phase_reg <= phase_reg + stft_pkg::HOP_W'(1);
                end
                pos_reg <= pos_reg + FW'(1);
            end
        end
    end

    // item snapshot
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cur_ch_reg    <= in_ch[CHW-1:0];
            cur_pos_reg   <= pos_reg[LOGN-1:0];
            cur_frame_reg <= frame_cnt_reg;
        end
    end

    // sequencing counters
    logic [HAW-1:0]  clr_cnt_reg;
    logic [LOGN-1:0] n_reg;
    logic [BW-1:0]   b_reg;
    logic [STW-1:0]  stage_reg;
    logic [LOGN-1:0] bin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            n_reg       <= '0;
            b_reg       <= '0;
            stage_reg   <= '0;
            bin_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + HAW'(1);
            if (cmd.take)
            begin
                n_reg     <= '0;
                b_reg     <= '0;
                stage_reg <= '0;
                bin_reg   <= '0;
            end
            else
            begin
                if (cmd.ld_wr)
                    n_reg <= n_reg + LOGN'(1);
                if (cmd.bf_wr_q)
                begin
                    if (b_reg == '1)
                    begin
                        b_reg     <= '0;
                        stage_reg <= stage_reg + STW'(1);
                    end
                    else
                        b_reg <= b_reg + BW'(1);
                end
                if (cmd.out_ld)
                    bin_reg <= bin_reg + LOGN'(1);
            end
        end
    end

    // sample history memory
    logic [SW-1:0]   hist_mem [HDEPTH];
    logic [SW-1:0]   hist_rd_reg;
    logic            hist_we;
    logic [HAW-1:0]  hist_wa;
    logic [SW-1:0]   hist_wd;
    logic [HAW-1:0]  hist_ra;
    logic [LOGN-1:0] rd_off;

    assign hist_we = cmd.clr_step | (cmd.take & in_valid);
    assign hist_wa = cmd.clr_step ? clr_cnt_reg
                                  : HAW'({in_ch[CHW-1:0], pos_reg[LOGN-1:0]});
    assign hist_wd = (cmd.clr_step || in_pad) ? '0 : in_sample;
    assign rd_off  = cur_pos_reg + LOGN'(1) + n_reg;
    assign hist_ra = HAW'({cur_ch_reg, rd_off});

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_wa] <= hist_wd;
        if (cmd.ld_rd)
            hist_rd_reg <= hist_mem[hist_ra];
    end

    // windowing
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_rnd;
    logic [DW-1:0]        ld_val;
    logic [LOGN-1:0]      ld_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.ld_mul)
            prod_reg <= $signed(hist_rd_reg)
                        * $signed({1'b0, WIN_TAB[stft_pkg::MAX_LOG'(n_reg)]});
    end

    assign prod_rnd = prod_reg + RND_P;
    assign ld_val   = DW'(prod_rnd >>> 15);

    // bit-reversed load address
    always_comb
    begin
        for (int i = 0; i < LOGN; i++)
            ld_addr[i] = n_reg[LOGN-1-i];
    end

    // butterfly addressing
    logic [BW-1:0]   mask;
    logic [BW-1:0]   j_idx;
    logic [BW-1:0]   tw_k;
    logic [LOGN-1:0] p_addr;
    logic [LOGN-1:0] q_addr;

    assign mask   = (BW'(1) << stage_reg) - BW'(1);
    assign j_idx  = b_reg & mask;
    assign tw_k   = BW'(j_idx << (STW'(BW) - stage_reg));
    assign p_addr = (LOGN'(b_reg & ~mask) << 1) | LOGN'(j_idx);
    assign q_addr = p_addr | (LOGN'(1) << stage_reg);

    // work memory, imaginary in the upper half
    logic [2*DW-1:0] work_mem [FRAME_LEN];
    logic [2*DW-1:0] rd_a_reg;
    logic [2*DW-1:0] rd_b_reg;
    logic [LOGN-1:0] rd_a_addr;
    logic            work_we;
    logic [LOGN-1:0] work_wa;
    logic [2*DW-1:0] work_wd;

    logic signed [DW-1:0] re_a;
    logic signed [DW-1:0] im_a;
    logic signed [DW-1:0] re_b;
    logic signed [DW-1:0] im_b;
    logic signed [DW-1:0] tr_reg;
    logic signed [DW-1:0] ti_reg;
    logic signed [stft_pkg::TW_W-1:0] cos_reg;
    logic signed [stft_pkg::TW_W-1:0] sin_reg;

    assign re_a = rd_a_reg[DW-1:0];
    assign im_a = rd_a_reg[2*DW-1:DW];
    assign re_b = rd_b_reg[DW-1:0];
    assign im_b = rd_b_reg[2*DW-1:DW];

    assign rd_a_addr = cmd.out_rd ? bin_reg : p_addr;

    always_comb
    begin
        work_we = cmd.ld_wr | cmd.bf_wr_p | cmd.bf_wr_q;
        work_wa = ld_addr;
        work_wd = {{DW{1'b0}}, ld_val};
        if (cmd.bf_wr_p)
        begin
            work_wa = p_addr;
            work_wd = {im_a + ti_reg, re_a + tr_reg};
        end
        else if (cmd.bf_wr_q)
        begin
            work_wa = q_addr;
            work_wd = {im_a - ti_reg, re_a - tr_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[work_wa] <= work_wd;
        if (cmd.bf_rd || cmd.out_rd)
            rd_a_reg <= work_mem[rd_a_addr];
        if (cmd.bf_rd)
        begin
            rd_b_reg <= work_mem[q_addr];
            cos_reg  <= COS_TAB[(stft_pkg::MAX_LOG-1)'(tw_k)];
            sin_reg  <= SIN_TAB[(stft_pkg::MAX_LOG-1)'(tw_k)];
        end
    end

    // twiddle products
    logic signed [MW-1:0] mrc_reg;
    logic signed [MW-1:0] mis_reg;
    logic signed [MW-1:0] mic_reg;
    logic signed [MW-1:0] mrs_reg;
    logic signed [MW:0]   sum_r;
    logic signed [MW:0]   sum_i;

    always_ff @(posedge clk)
    begin
        if (cmd.bf_mul)
        begin
            mrc_reg <= re_b * cos_reg;
            mis_reg <= im_b * sin_reg;
            mic_reg <= im_b * cos_reg;
            mrs_reg <= re_b * sin_reg;
        end
    end

    // rounded rotation
    assign sum_r = mrc_reg + mis_reg + RND_M;
    assign sum_i = mic_reg - mrs_reg + RND_M;

    always_ff @(posedge clk)
    begin
        if (cmd.bf_sum)
        begin
            tr_reg <= DW'(sum_r >>> 15);
            ti_reg <= DW'(sum_i >>> 15);
        end
    end

    // output register
    logic                        m_tvalid_reg;
    logic [stft_pkg::CH_W-1:0]   out_ch_reg;
    logic [FW-1:0]               out_frame_reg;
    logic [stft_pkg::BIN_W-1:0]  out_bin_reg;
    logic [stft_pkg::OUT_W-1:0]  out_re_reg;
    logic [stft_pkg::OUT_W-1:0]  out_im_reg;
    logic                        out_last_reg;
    logic                        out_last;

    assign out_last = (bin_reg == LOGN'(HALF));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.out_ld)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_ch_reg    <= stft_pkg::CH_W'(cur_ch_reg);
            out_frame_reg <= cur_frame_reg;
            out_bin_reg   <= stft_pkg::BIN_W'(bin_reg);
            out_re_reg    <= stft_pkg::sat_out(re_a);
            out_im_reg    <= stft_pkg::sat_out(im_a);
            out_last_reg  <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_im_reg, out_re_reg, out_bin_reg, out_frame_reg, out_ch_reg};
    assign m_tlast  = out_last_reg;

    // status
    assign sts.clr_done  = (clr_cnt_reg == HAW'(HDEPTH - 1));
    assign sts.frame_due = frame_due;
    assign sts.ld_last   = (n_reg == '1);
    assign sts.bf_last   = (b_reg == '1) && (stage_reg == STW'(LOGN - 1));
    assign sts.out_last  = out_last;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

endmodule

@@ rtl/stft_hann_analysis_top.sv @@
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata: channel, sample; tuser: kind
// m_*       out  tvalid/tready      tdata: channel, frame, bin, real, imag; tlast
// apb       in   psel/penable       channel_count at 0x0, hop_length at 0x4
//
// an item that completes no frame is taken without a transform; an item that completes a frame
// is followed by the window load, the butterfly passes and the bin output before the next item
// is taken, paced by the single butterfly unit and the work memory write port
// after reset a clearing pass over all MAX_CHANNELS*FRAME_LEN (512) history entries holds s_tready low
// a stalled output holds the bin sequencer; the next item is taken while the last bin waits
`include "assert_macros.svh"

module stft_hann_analysis_top #(
    parameter int FRAME_LEN    = stft_pkg::FRAME_LEN_DEF,
    parameter int MAX_CHANNELS = stft_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stft_pkg::APB_AW-1:0]       paddr,
    input  logic [stft_pkg::APB_DW-1:0]       pwdata,
    output logic [stft_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [stft_pkg::TDATA_IN_W-1:0]   s_tdata,   // channel[2:0], sample[18:3], zero
    input  logic                              s_tuser,   // kind[0]
    // bin stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [stft_pkg::TDATA_OUT_W-1:0]  m_tdata,   // out_channel[2:0], frame_index[34:3],
                                                         // bin_index[40:35], real_part[63:41],
                                                         // imag_part[86:64], zero
    output logic                              m_tlast    // last_bin
);

    logic [stft_pkg::CC_W-1:0]  channel_count_reg;
    logic [stft_pkg::HOP_W-1:0] hop_length_reg;
    logic                       cfg_wr;
    stft_pkg::reg_idx_t         cfg_idx;

    stft_pkg::cmd_t cmd;
    stft_pkg::sts_t sts;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = stft_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= stft_pkg::CC_RESET;
            hop_length_reg    <= stft_pkg::HOP_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                stft_pkg::REG_CHANNEL_COUNT: channel_count_reg <= pwdata[stft_pkg::CC_W-1:0];
                stft_pkg::REG_HOP_LENGTH:    hop_length_reg    <= pwdata[stft_pkg::HOP_W-1:0];
                default:                     channel_count_reg <= channel_count_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            stft_pkg::REG_CHANNEL_COUNT:
                prdata = stft_pkg::APB_DW'(channel_count_reg);
            stft_pkg::REG_HOP_LENGTH:
                prdata = stft_pkg::APB_DW'(hop_length_reg);
            default:
                prdata = '0;
        endcase
    end

    // sequencer
    stft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // history, window, fft and output datapath
    stft_dp #(
        .FRAME_LEN    (FRAME_LEN),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .channel_count (channel_count_reg),
        .hop_length    (hop_length_reg),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

    // checks
    `ASSERT_CLK(a_busy_after_frame, (s_tvalid && s_tready && sts.frame_due) |=> !s_tready, "request with a due frame did not start the transform")
    `ASSERT_NEVER(a_last_is_nyquist, m_tvalid && m_tlast && (m_tdata[40:35] != 6'(FRAME_LEN/2)), "last bin flag on a bin other than frame size over two")
    `ASSERT_CLK(a_cc_write, (psel && penable && pwrite && !paddr[2]) |=> (channel_count_reg == $past(pwdata[3:0])), "channel count write lost")

endmodule
